// ===== rtl/core/lod_pkg.sv =====
package lod_pkg;

  localparam int unsigned COV_W    = 24;
  localparam int unsigned BIAS_W   = 12;
  localparam int unsigned SUM_W    = 14;
  localparam int unsigned FRAC_W   = 8;
  localparam int unsigned EXP_W    = 6;
  localparam int unsigned MUL_W    = 17;
  localparam int unsigned LVL_W    = 3;
  localparam int unsigned CNT_W    = 4;
  localparam int unsigned BAND_W   = 32;
  localparam int unsigned NUM_W    = 33;
  localparam int unsigned WGT_W    = 17;
  localparam int unsigned QUO_W    = 16;
  localparam int unsigned NUM_THRESH = 8;

  localparam logic [COV_W-1:0] COVER_MAX = 24'hFFFFFF;
  localparam logic [15:0]      HYST_MAX  = 16'd58982;
  localparam logic [MUL_W-1:0] MUL_ONE   = 17'd65536;
  localparam logic [WGT_W-1:0] WGT_FULL  = 17'd65536;

  localparam logic [1:0] REG_SCENE_BIAS  = 2'd0;
  localparam logic [1:0] REG_CAMERA_BIAS = 2'd1;
  localparam logic [1:0] REG_HYST_FRAC   = 2'd2;
  localparam logic [1:0] REG_FADE_BAND   = 2'd3;

  typedef logic [MUL_W-1:0] mul_tab_t [256];

  function automatic mul_tab_t build_frac_tab();
    logic [63:0] tab [8];
    logic [63:0] m;
    mul_tab_t    res;
    tab[0] = 64'd92682; tab[1] = 64'd77936; tab[2] = 64'd71468; tab[3] = 64'd68438;
    tab[4] = 64'd66971; tab[5] = 64'd66250; tab[6] = 64'd65892; tab[7] = 64'd65714;
    for (int f = 0; f < 256; f++) begin
      m = 64'd65536;
      for (int k = 0; k < 8; k++) begin
        if (((f >> (7 - k)) & 1) != 0) begin
          m = (m * tab[k] + 64'd32768) >> 16;
        end
      end
      res[f] = m[MUL_W-1:0];
    end
    return res;
  endfunction

  typedef struct packed {
    logic              hit;
    logic              inb;
    logic [NUM_W-1:0]  num;
    logic [BAND_W-1:0] band;
  } lane_res_t;

  typedef struct packed {
    logic [LVL_W-1:0]  chosen;
    logic              active;
    logic              empty;
    logic [NUM_W-1:0]  num;
    logic [BAND_W-1:0] band;
  } div_req_t;

  typedef struct packed {
    logic [LVL_W-1:0] chosen;
    logic             active;
    logic             empty;
    logic             sat;
  } div_meta_t;

endpackage

// ===== rtl/core/lod_if.sv =====
interface lod_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] coverage_q;
  logic signed [11:0] instance_bias_q;
  logic [3:0]  prior_level;
  logic [3:0]  level_total;
  logic [23:0] thresh_0;
  logic [23:0] thresh_1;
  logic [23:0] thresh_2;
  logic [23:0] thresh_3;
  logic [23:0] thresh_4;
  logic [23:0] thresh_5;
  logic [23:0] thresh_6;
  logic [23:0] thresh_7;

  modport source (
    output valid, coverage_q, instance_bias_q, prior_level, level_total,
    output thresh_0, thresh_1, thresh_2, thresh_3, thresh_4, thresh_5, thresh_6, thresh_7,
    input  ready
  );
  modport sink (
    input  valid, coverage_q, instance_bias_q, prior_level, level_total,
    input  thresh_0, thresh_1, thresh_2, thresh_3, thresh_4, thresh_5, thresh_6, thresh_7,
    output ready
  );
endinterface

interface lod_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  chosen_level;
  logic        fade_active;
  logic [2:0]  fade_level;
  logic [16:0] fade_weight;
  logic        chain_empty;

  modport source (
    output valid, chosen_level, fade_active, fade_level, fade_weight, chain_empty,
    input  ready
  );
  modport sink (
    input  valid, chosen_level, fade_active, fade_level, fade_weight, chain_empty,
    output ready
  );
endinterface

// ===== rtl/core/lod_level_select.sv =====
// Level-of-detail selector: each beat carries one instance's coverage, bias, prior level and
// threshold chain and yields one result beat. Coverage is scaled by 2^((scene+camera+instance
// bias)/256), thresholds get hysteresis per lane, the first reached level wins, and a cross-fade
// weight is produced when coverage sits in the band above the chosen threshold. Throughput is
// one beat per cycle unless rsp.ready stalls; a 16-step pipelined divider forms the fade weight.
// The user must write registers over the APB port while the block is idle; it is not enforced.
module lod_level_select #(
  parameter int unsigned MAX_LEVELS = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  lod_in_if.sink       req,
  lod_out_if.source    rsp
);

  localparam int unsigned FRONT = 5;
  localparam int unsigned NST   = FRONT + lod_pkg::QUO_W;
  localparam lod_pkg::mul_tab_t FRAC_MUL = lod_pkg::build_frac_tab();
  localparam logic [lod_pkg::CNT_W-1:0] LVL_MAX = lod_pkg::CNT_W'(MAX_LEVELS);

  logic signed [11:0] scene_bias;
  logic signed [11:0] camera_bias;
  logic [15:0]        hysteresis_frac;
  logic [15:0]        fade_band_frac;

  logic [NST-1:0] vld;
  logic [NST-1:0] en;

  // config port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scene_bias      <= '0;
      camera_bias     <= '0;
      hysteresis_frac <= '0;
      fade_band_frac  <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        lod_pkg::REG_SCENE_BIAS:  scene_bias      <= pwdata[11:0];
        lod_pkg::REG_CAMERA_BIAS: camera_bias     <= pwdata[11:0];
        lod_pkg::REG_HYST_FRAC:   hysteresis_frac <= pwdata[15:0];
        lod_pkg::REG_FADE_BAND:   fade_band_frac  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      lod_pkg::REG_SCENE_BIAS:  prdata = {{20{scene_bias[11]}}, scene_bias};
      lod_pkg::REG_CAMERA_BIAS: prdata = {{20{camera_bias[11]}}, camera_bias};
      lod_pkg::REG_HYST_FRAC:   prdata = {16'b0, hysteresis_frac};
      lod_pkg::REG_FADE_BAND:   prdata = {16'b0, fade_band_frac};
      default:                  prdata = '0;
    endcase
  end

  // stall chain
  always_comb begin
    en[NST-1] = !vld[NST-1] || rsp.ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign req.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= req.valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // stage a: bias sum and fraction lookup
  logic signed [lod_pkg::SUM_W-1:0] bias_sum;
  logic [lod_pkg::COV_W-1:0]        th_in [lod_pkg::NUM_THRESH];
  logic [15:0]                      hyst;

  assign bias_sum = lod_pkg::SUM_W'(scene_bias) + lod_pkg::SUM_W'(camera_bias)
                  + lod_pkg::SUM_W'(req.instance_bias_q);
  assign hyst     = hysteresis_frac > lod_pkg::HYST_MAX ? lod_pkg::HYST_MAX : hysteresis_frac;

  assign th_in[0] = req.thresh_0;
  assign th_in[1] = req.thresh_1;
  assign th_in[2] = req.thresh_2;
  assign th_in[3] = req.thresh_3;
  assign th_in[4] = req.thresh_4;
  assign th_in[5] = req.thresh_5;
  assign th_in[6] = req.thresh_6;
  assign th_in[7] = req.thresh_7;

  logic [lod_pkg::COV_W-1:0]        cov_a;
  logic [lod_pkg::MUL_W-1:0]        mul_a;
  logic signed [lod_pkg::EXP_W-1:0] exp_a;
  logic [lod_pkg::CNT_W-1:0]        prior_a;
  logic                             held_a;
  logic [lod_pkg::CNT_W-1:0]        count_a;
  logic                             empty_a;
  logic [lod_pkg::COV_W-1:0]        th_a [MAX_LEVELS];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      cov_a   <= req.coverage_q;
      mul_a   <= FRAC_MUL[bias_sum[lod_pkg::FRAC_W-1:0]];
      exp_a   <= bias_sum[lod_pkg::SUM_W-1:lod_pkg::FRAC_W];
      prior_a <= req.prior_level;
      held_a  <= !req.prior_level[3];
      count_a <= req.level_total > LVL_MAX ? LVL_MAX : req.level_total;
      empty_a <= req.level_total == '0;
      for (int i = 0; i < MAX_LEVELS; i++) begin
        th_a[i] <= th_in[i];
      end
    end
  end

  // stage b: coverage times fraction multiplier
  logic [lod_pkg::COV_W+lod_pkg::MUL_W-1:0] prod_b;
  logic signed [lod_pkg::EXP_W-1:0]         exp_b;
  logic [lod_pkg::CNT_W-1:0]                count_b;
  logic                                     empty_b;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      prod_b  <= cov_a * mul_a;
      exp_b   <= exp_a;
      count_b <= count_a;
      empty_b <= empty_a;
    end
  end

  // stage c: exponent shift and saturation
  logic [47:0]               wide_c;
  logic [5:0]                rsh;
  logic [5:0]                lsh;
  logic [lod_pkg::COV_W-1:0] biased;
  logic [lod_pkg::CNT_W-1:0] count_c;
  logic                      empty_c;

  assign rsh = 6'(6'sd16 - exp_b);
  assign lsh = 6'(exp_b - 6'sd16);

  always_comb begin
    if (exp_b <= 6'sd16) begin
      wide_c = {7'b0, prod_b} >> rsh;
    end else begin
      wide_c = {7'b0, prod_b} << lsh;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      biased  <= wide_c > {24'b0, lod_pkg::COVER_MAX} ? lod_pkg::COVER_MAX
                                                      : wide_c[lod_pkg::COV_W-1:0];
      count_c <= count_b;
      empty_c <= empty_b;
    end
  end

  // stage d: lanes compare
  lod_pkg::lane_res_t        lane_res [MAX_LEVELS];
  logic [lod_pkg::CNT_W-1:0] count_d;
  logic                      empty_d;

  for (genvar i = 0; i < MAX_LEVELS; i++) begin : g_lane
    lod_lane #(.IDX(i)) u_lane (
      .clk       (clk),
      .en        (en[3:1]),
      .thresh    (th_a[i]),
      .held      (held_a),
      .prior     (prior_a),
      .hyst      (hyst),
      .band_frac (fade_band_frac),
      .biased    (biased),
      .res       (lane_res[i])
    );
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      count_d <= count_c;
      empty_d <= empty_c;
    end
  end

  // stage e: merge
  lod_pkg::div_req_t div_req;

  lod_merge #(.LANES(MAX_LEVELS)) u_merge (
    .clk     (clk),
    .en      (en[4]),
    .res     (lane_res),
    .count   (count_d),
    .empty   (empty_d),
    .band_on (fade_band_frac != '0),
    .req     (div_req)
  );

  // fade weight divider
  lod_pkg::div_meta_t        meta;
  logic [lod_pkg::QUO_W-1:0] quo;

  lod_div u_div (
    .clk      (clk),
    .en       (en[NST-1:FRONT]),
    .req      (div_req),
    .meta_out (meta),
    .quo_out  (quo)
  );

  assign rsp.valid        = vld[NST-1];
  assign rsp.chosen_level = meta.chosen;
  assign rsp.chain_empty  = meta.empty;
  assign rsp.fade_active  = meta.active;
  assign rsp.fade_level   = meta.active ? meta.chosen + 3'd1 : 3'd0;
  assign rsp.fade_weight  = !meta.active ? '0 :
                            meta.sat ? lod_pkg::WGT_FULL : {1'b0, quo};

endmodule

// ===== rtl/core/lod_lane.sv =====
module lod_lane #(
  parameter int unsigned IDX = 0
) (
  input  logic                            clk,
  input  logic [2:0]                      en,
  input  logic [lod_pkg::COV_W-1:0]       thresh,
  input  logic                            held,
  input  logic [lod_pkg::CNT_W-1:0]       prior,
  input  logic [15:0]                     hyst,
  input  logic [15:0]                     band_frac,
  input  logic [lod_pkg::COV_W-1:0]       biased,
  output lod_pkg::lane_res_t              res
);

  localparam logic [lod_pkg::CNT_W-1:0] MY_IDX = lod_pkg::CNT_W'(IDX);

  logic [lod_pkg::MUL_W-1:0]        mul;
  logic [lod_pkg::COV_W-1:0]        tb;
  logic [lod_pkg::COV_W+lod_pkg::MUL_W-1:0] adj_prod;
  logic [lod_pkg::COV_W+15:0]       band_prod;
  logic [lod_pkg::COV_W-1:0]        tc;
  logic [lod_pkg::COV_W:0]          adj_c;
  logic [lod_pkg::BAND_W-1:0]       band_c;
  logic [lod_pkg::NUM_W-1:0]        top_c;

  always_comb begin
    if (held && MY_IDX == prior) begin
      mul = lod_pkg::MUL_ONE - {1'b0, hyst};
    end else if (held && MY_IDX < prior) begin
      mul = lod_pkg::MUL_ONE + {1'b0, hyst};
    end else begin
      mul = lod_pkg::MUL_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      tb        <= thresh;
      adj_prod  <= thresh * mul;
      band_prod <= thresh * band_frac;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      tc     <= tb;
      adj_c  <= adj_prod[lod_pkg::COV_W+lod_pkg::MUL_W-1:16];
      band_c <= band_prod[lod_pkg::COV_W+15:8];
    end
  end

  assign top_c = {9'b0, tc} + {1'b0, band_c};

  always_ff @(posedge clk) begin
    if (en[2]) begin
      res.hit  <= {1'b0, biased} >= adj_c;
      res.inb  <= {9'b0, biased} < top_c;
      res.num  <= top_c - {9'b0, biased};
      res.band <= band_c;
    end
  end

endmodule

// ===== rtl/core/lod_merge.sv =====
module lod_merge #(
  parameter int unsigned LANES = 8
) (
  input  logic                       clk,
  input  logic                       en,
  input  lod_pkg::lane_res_t         res [LANES],
  input  logic [lod_pkg::CNT_W-1:0]  count,
  input  logic                       empty,
  input  logic                       band_on,
  output lod_pkg::div_req_t          req
);

  logic [lod_pkg::LVL_W-1:0] chosen;
  logic [lod_pkg::CNT_W-1:0] next_lvl;
  lod_pkg::lane_res_t        sel;
  logic                      active;

  always_comb begin
    chosen = lod_pkg::LVL_W'(count - 4'd1);
    for (int i = LANES - 1; i >= 0; i--) begin
      if (res[i].hit && lod_pkg::CNT_W'(i) < count) begin
        chosen = lod_pkg::LVL_W'(i);
      end
    end
    if (empty) begin
      chosen = '0;
    end
    sel      = res[chosen];
    next_lvl = {1'b0, chosen} + 4'd1;
    active   = !empty && band_on && next_lvl < count && sel.band != '0 && sel.inb;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      req.chosen <= chosen;
      req.active <= active;
      req.empty  <= empty;
      req.num    <= sel.num;
      req.band   <= sel.band;
    end
  end

endmodule

// ===== rtl/core/lod_div.sv =====
module lod_div (
  input  logic                          clk,
  input  logic [lod_pkg::QUO_W-1:0]     en,
  input  lod_pkg::div_req_t             req,
  output lod_pkg::div_meta_t            meta_out,
  output logic [lod_pkg::QUO_W-1:0]     quo_out
);

  localparam int unsigned N = lod_pkg::QUO_W;

  logic [lod_pkg::BAND_W-1:0] rem  [N];
  logic [lod_pkg::BAND_W-1:0] band [N];
  logic [N-1:0]               quo  [N];
  lod_pkg::div_meta_t         meta [N];

  logic [lod_pkg::BAND_W-1:0] rem_in  [N];
  logic [lod_pkg::BAND_W-1:0] band_in [N];
  logic [N-1:0]               quo_in  [N];
  lod_pkg::div_meta_t         meta_in [N];

  always_comb begin
    meta_in[0].chosen = req.chosen;
    meta_in[0].active = req.active;
    meta_in[0].empty  = req.empty;
    meta_in[0].sat    = req.num >= {1'b0, req.band};
    rem_in[0]  = req.num[lod_pkg::BAND_W-1:0];
    band_in[0] = req.band;
    quo_in[0]  = '0;
  end

  for (genvar j = 1; j < N; j++) begin : g_link
    assign rem_in[j]  = rem[j-1];
    assign band_in[j] = band[j-1];
    assign quo_in[j]  = quo[j-1];
    assign meta_in[j] = meta[j-1];
  end

  for (genvar j = 0; j < N; j++) begin : g_step
    logic [lod_pkg::BAND_W:0] dbl;
    logic                     ge;
    logic [lod_pkg::BAND_W:0] diff;
    assign dbl  = {rem_in[j], 1'b0};
    assign ge   = dbl >= {1'b0, band_in[j]};
    assign diff = dbl - {1'b0, band_in[j]};
    always_ff @(posedge clk) begin
      if (en[j]) begin
        rem[j]  <= ge ? diff[lod_pkg::BAND_W-1:0] : dbl[lod_pkg::BAND_W-1:0];
        band[j] <= band_in[j];
        quo[j]  <= {quo_in[j][N-2:0], ge};
        meta[j] <= meta_in[j];
      end
    end
  end

  assign meta_out = meta[N-1];
  assign quo_out  = quo[N-1];

endmodule

// ===== test/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [23:0]        cov;
    logic signed [11:0] ibias;
    logic [3:0]         prior;
    logic [3:0]         total;
    logic [23:0]        th [8];
  } lod_item_t;

  typedef struct packed {
    logic [2:0]  level;
    logic        active;
    logic [2:0]  flevel;
    logic [16:0] weight;
    logic        empty;
  } lod_res_t;

  class lod_scoreboard;
    logic [11:0]     gbias, vbias;
    logic [15:0]     hyst, band_frac;
    longint unsigned root_tab [8];
    lod_res_t        pending [$];
    int              errors, items, results, fades, empties;

    function new();
      root_tab = '{92682, 77936, 71468, 68438, 66971, 66250, 65892, 65714};
      gbias = 0; vbias = 0; hyst = 0; band_frac = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] v);
      case (idx)
        lod_pkg::REG_SCENE_BIAS:  gbias = v[11:0];
        lod_pkg::REG_CAMERA_BIAS: vbias = v[11:0];
        lod_pkg::REG_HYST_FRAC:   hyst = v[15:0];
        lod_pkg::REG_FADE_BAND:   band_frac = v[15:0];
        default: ;
      endcase
    endfunction

    function longint unsigned scaled(lod_item_t it);
      int sum, e, frac, s;
      longint unsigned m, p, r;
      sum = $signed(gbias);
      sum += $signed(vbias);
      sum += it.ibias;
      e = sum >>> 8;
      frac = sum & 255;
      m = 65536;
      for (int k = 0; k < 8; k++)
        if (((frac >> (7 - k)) & 1) != 0) m = (m * root_tab[k] + 32768) >> 16;
      p = it.cov * m;
      s = 16 - e;
      r = (s >= 0) ? (p >> s) : (p << (-s));
      return (r > 64'hFFFFFF) ? 64'hFFFFFF : r;
    endfunction

    function lod_res_t select(lod_item_t it);
      lod_res_t        res;
      longint unsigned cov, h, t, band, w;
      int              cnt, chosen;
      bit              held;
      res = '0;
      if (it.total == 0) begin
        res.empty = 1;
        return res;
      end
      cnt = (it.total > 8) ? 8 : it.total;
      cov = scaled(it);
      h = (hyst > lod_pkg::HYST_MAX) ? lod_pkg::HYST_MAX : hyst;
      held = it.prior < 8;
      chosen = cnt - 1;
      for (int i = 0; i < cnt; i++) begin
        t = it.th[i];
        if (held && i == it.prior) t = (t * (65536 - h)) >> 16;
        else if (held && i < it.prior) t = (t * (65536 + h)) >> 16;
        if (cov >= t) begin
          chosen = i;
          break;
        end
      end
      res.level = chosen[2:0];
      if (band_frac != 0 && chosen + 1 < cnt) begin
        t = it.th[chosen];
        band = (t * band_frac) >> 8;
        if (band > 0 && cov < t + band) begin
          w = ((t + band - cov) << 16) / band;
          if (w > 65536) w = 65536;
          res.active = 1;
          res.flevel = chosen[2:0] + 3'd1;
          res.weight = w[16:0];
        end
      end
      return res;
    endfunction

    function void note(lod_item_t it);
      lod_res_t r;
      r = select(it);
      items++;
      if (r.active) fades++;
      if (r.empty) empties++;
      pending.push_back(r);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check(lod_res_t got);
      lod_res_t exp;
      results++;
      if (pending.size() == 0) begin
        report("result beat with nothing pending");
        return;
      end
      exp = pending.pop_front();
      if (got.level !== exp.level)
        report($sformatf("chosen_level %0d, want %0d", got.level, exp.level));
      if (got.active !== exp.active)
        report($sformatf("fade_active %0b, want %0b", got.active, exp.active));
      if (got.flevel !== exp.flevel)
        report($sformatf("fade_level %0d, want %0d", got.flevel, exp.flevel));
      if (got.weight !== exp.weight)
        report($sformatf("fade_weight %0d, want %0d", got.weight, exp.weight));
      if (got.empty !== exp.empty)
        report($sformatf("chain_empty %0b, want %0b", got.empty, exp.empty));
    endtask
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [3:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;

  lod_in_if  req ();
  lod_out_if rsp ();

  lod_level_select dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .req(req.sink), .rsp(rsp.source)
  );

  always #4 clk = ~clk;

  lod_scoreboard sb = new();
  int            idle_cycles = 0;
  int            burst_left = 0;
  int            stall_mode = 0;
  int            stall_cnt = 0;

  initial begin
    req.valid = 0;
    req.coverage_q = 0;
    req.instance_bias_q = 0;
    req.prior_level = 0;
    req.level_total = 0;
    req.thresh_0 = 0; req.thresh_1 = 0; req.thresh_2 = 0; req.thresh_3 = 0;
    req.thresh_4 = 0; req.thresh_5 = 0; req.thresh_6 = 0; req.thresh_7 = 0;
    rsp.ready = 0;
  end

  // monitor both channels
  always @(posedge clk) begin
    lod_item_t it;
    lod_res_t  got;
    bit        moved;
    if (!rst) begin
      moved = psel;
      if (req.valid && req.ready) begin
        it.cov = req.coverage_q;
        it.ibias = req.instance_bias_q;
        it.prior = req.prior_level;
        it.total = req.level_total;
        it.th = '{req.thresh_0, req.thresh_1, req.thresh_2, req.thresh_3,
                  req.thresh_4, req.thresh_5, req.thresh_6, req.thresh_7};
        sb.note(it);
        moved = 1'b1;
      end
      if (rsp.valid && rsp.ready) begin
        got.level = rsp.chosen_level;
        got.active = rsp.fade_active;
        got.flevel = rsp.fade_level;
        got.weight = rsp.fade_weight;
        got.empty = rsp.chain_empty;
        sb.check(got);
        moved = 1'b1;
      end
      if (idle_cycles > 4000) begin
        $display("watchdog: no beat for %0d cycles", idle_cycles);
        $display("tb: errors");
        $finish;
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (stall_cnt == 0) begin
      stall_mode <= int'($urandom_range(0, 3));
      stall_cnt <= int'($urandom_range(16, 96));
    end else begin
      stall_cnt <= stall_cnt - 1;
    end
    case (stall_mode)
      0: rsp.ready <= 1'b1;
      1: rsp.ready <= 1'($urandom_range(0, 1));
      2: rsp.ready <= ($urandom_range(0, 3) == 0);
      default: rsp.ready <= (stall_cnt % 7) < 4;
    endcase
  end

  task apb_write(logic [1:0] idx, logic [31:0] v);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.write_reg(idx, v);
  endtask

  task send(lod_item_t it);
    if (burst_left == 0) begin
      req.valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? int'($urandom_range(30, 80))
                                               : int'($urandom_range(1, 12));
    end
    req.valid <= 1;
    req.coverage_q <= it.cov;
    req.instance_bias_q <= it.ibias;
    req.prior_level <= it.prior;
    req.level_total <= it.total;
    req.thresh_0 <= it.th[0]; req.thresh_1 <= it.th[1];
    req.thresh_2 <= it.th[2]; req.thresh_3 <= it.th[3];
    req.thresh_4 <= it.th[4]; req.thresh_5 <= it.th[5];
    req.thresh_6 <= it.th[6]; req.thresh_7 <= it.th[7];
    do @(posedge clk); while (!req.ready);
    burst_left--;
  endtask

  task drain();
    req.valid <= 0;
    burst_left = 0;
    do @(posedge clk); while (sb.pending.size() != 0);
    repeat (25) @(posedge clk);
  endtask

  function automatic lod_item_t chain(logic [23:0] cov, logic signed [11:0] ib,
                                      logic [3:0] prior, logic [3:0] total,
                                      logic [23:0] t0);
    lod_item_t it;
    it.cov = cov; it.ibias = ib; it.prior = prior; it.total = total;
    for (int i = 0; i < 8; i++) it.th[i] = t0 >> i;
    return it;
  endfunction

  function automatic lod_item_t rand_item();
    lod_item_t       it;
    int              j, pct;
    longint signed   c;
    it.total = ($urandom_range(0, 9) != 0) ? 4'($urandom_range(1, 8))
                                           : 4'($urandom_range(0, 15));
    if (it.total > 8 && $urandom_range(0, 1)) it.total = 4'd0;
    it.prior = ($urandom_range(0, 4) != 0) ? 4'($urandom_range(0, 7))
                                           : 4'($urandom_range(8, 15));
    it.th[0] = 24'($urandom_range(0, 24'hFFFFFF));
    for (int i = 1; i < 8; i++) begin
      pct = int'($urandom_range(20, 95));
      it.th[i] = ($urandom_range(0, 9) == 0) ? 24'($urandom) : 24'((it.th[i-1] * pct) / 100);
    end
    if ($urandom_range(0, 3) == 0) begin
      it.cov = 24'($urandom_range(0, 24'hFFFFFF));
    end else begin
      j = int'($urandom_range(0, 7));
      c = longint'(it.th[j]) + ($signed($urandom) % (longint'(it.th[j]) / 3 + 2));
      it.cov = (c < 0) ? 24'd0 : (c > 24'hFFFFFF) ? 24'hFFFFFF : 24'(c);
    end
    it.ibias = ($urandom_range(0, 9) < 7) ? 12'($signed($urandom_range(0, 600)) - 300)
                                          : 12'($urandom);
    return it;
  endfunction

  initial begin
    lod_item_t dir [$];
    repeat (8) @(posedge clk);
    rst <= 0;

    // reset register values, corner items
    dir.push_back(chain(24'h010000, 12'sd0, 4'd8, 4'd0, 24'h800000));
    dir.push_back(chain(24'h010000, 12'sd0, 4'd8, 4'd15, 24'h800000));
    dir.push_back(chain(24'h010000, 12'sd0, 4'd3, 4'd9, 24'h800000));
    dir.push_back(chain(24'h000000, 12'sd0, 4'd0, 4'd8, 24'h800000));
    dir.push_back(chain(24'hFFFFFF, 12'sd0, 4'd7, 4'd8, 24'hFFFFFF));
    dir.push_back(chain(24'h000000, 12'sd0, 4'd15, 4'd8, 24'h000000));
    dir.push_back(chain(24'h123456, -12'sd2048, 4'd8, 4'd8, 24'h400000));
    dir.push_back(chain(24'h123456, 12'sd2047, 4'd8, 4'd8, 24'h400000));
    dir.push_back(chain(24'hFFFFFF, 12'sd2047, 4'd0, 4'd1, 24'hFFFFFF));
    dir.push_back(chain(24'h000001, -12'sd1, 4'd8, 4'd4, 24'h000002));
    foreach (dir[i]) send(dir[i]);
    drain();

    // hysteresis and fade corners
    apb_write(lod_pkg::REG_SCENE_BIAS, 32'd0);
    apb_write(lod_pkg::REG_CAMERA_BIAS, 32'd0);
    apb_write(lod_pkg::REG_HYST_FRAC, 32'd16384);
    apb_write(lod_pkg::REG_FADE_BAND, 32'd128);
    dir.delete();
    dir.push_back(chain(24'h400000, 12'sd0, 4'd1, 4'd8, 24'h800000));
    dir.push_back(chain(24'h3A0000, 12'sd0, 4'd1, 4'd8, 24'h800000));
    dir.push_back(chain(24'h900000, 12'sd0, 4'd0, 4'd8, 24'h800000));
    dir.push_back(chain(24'h7C0000, 12'sd0, 4'd0, 4'd8, 24'h800000));
    dir.push_back(chain(24'h440000, 12'sd0, 4'd2, 4'd8, 24'h800000));
    dir.push_back(chain(24'h420000, 12'sd0, 4'd8, 4'd8, 24'h800000));
    dir.push_back(chain(24'h020000, 12'sd0, 4'd8, 4'd8, 24'h800000));
    dir.push_back(chain(24'h000500, 12'sd0, 4'd8, 4'd8, 24'h000001));
    dir.push_back(chain(24'h008000, 12'sd0, 4'd6, 4'd8, 24'h800000));
    dir.push_back(chain(24'hC00000, 12'sd0, 4'd8, 4'd8, 24'h800000));
    dir.push_back(chain(24'h480000, 12'sd0, 4'd8, 4'd3, 24'h800000));
    foreach (dir[i]) send(dir[i]);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          apb_write(lod_pkg::REG_SCENE_BIAS, 32'hFFFFF800);
          apb_write(lod_pkg::REG_CAMERA_BIAS, 32'hFFFFF800);
          apb_write(lod_pkg::REG_HYST_FRAC, 32'd65535);
          apb_write(lod_pkg::REG_FADE_BAND, 32'd65535);
        end
        1: begin
          apb_write(lod_pkg::REG_SCENE_BIAS, 32'd2047);
          apb_write(lod_pkg::REG_CAMERA_BIAS, 32'd2047);
          apb_write(lod_pkg::REG_HYST_FRAC, 32'd0);
          apb_write(lod_pkg::REG_FADE_BAND, 32'd0);
        end
        2: begin
          apb_write(lod_pkg::REG_SCENE_BIAS, 32'd0);
          apb_write(lod_pkg::REG_CAMERA_BIAS, 32'd0);
          apb_write(lod_pkg::REG_HYST_FRAC, 32'd58982);
          apb_write(lod_pkg::REG_FADE_BAND, 32'd1);
        end
        default: begin
          apb_write(lod_pkg::REG_SCENE_BIAS, 32'($signed($urandom_range(0, 512)) - 256));
          apb_write(lod_pkg::REG_CAMERA_BIAS, 32'($signed($urandom_range(0, 512)) - 256));
          apb_write(lod_pkg::REG_HYST_FRAC, $urandom_range(0, 65535));
          apb_write(lod_pkg::REG_FADE_BAND, $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                                      : $urandom_range(0, 512));
        end
      endcase
      repeat (200) send(rand_item());
      drain();
    end

    $display("covered %0d items, %0d results, %0d fades, %0d empty chains",
             sb.items, sb.results, sb.fades, sb.empties);
    $display("register settings from reset through both bias extremes and full hysteresis");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
